FILE: sv/modular_exponentiation_top_macros.svh
// Assertion macros used by the checker file of the modular exponentiation block.
`ifndef MODULAR_EXPONENTIATION_TOP_MACROS_SVH
`define MODULAR_EXPONENTIATION_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define MEXP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MEXP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/mexp_pkg.sv
// Package with the shared constants and types of the modular exponentiation block.
package mexp_pkg;

	localparam int WORD_BITS_DEF = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_MULACC,
		ST_SQUARE,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		OPS_REDUCE,
		OPS_MULACC,
		OPS_SQUARE
	} opsel_t;

	typedef struct packed {
		logic   start;
		opsel_t sel;
	} mm_cmd_t;

endpackage

FILE: sv/mexp_if.sv
// Valid/ready channel interfaces for the operand, result and modulus write transactions.
interface mexp_in_if #(
	parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic [WORD_BITS-1:0] base_value;
	logic [WORD_BITS-1:0] exponent;

	modport source (output valid, output base_value, output exponent, input ready);
	modport sink (input valid, input base_value, input exponent, output ready);
endinterface

interface mexp_out_if #(
	parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic [WORD_BITS-1:0] power_result;
	logic                 modulus_error;

	modport source (output valid, output power_result, output modulus_error, input ready);
	modport sink (input valid, input power_result, input modulus_error, output ready);
endinterface

interface mexp_cfg_if #(
	parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic [WORD_BITS-1:0] modulus;

	modport source (output valid, output modulus, input ready);
	modport sink (input valid, input modulus, output ready);
endinterface

FILE: sv/mexp_mulmod.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, most significant bit first.
module mexp_mulmod #(
	parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_BITS-1:0] mcand,
	input  logic [WORD_BITS-1:0] mplier,
	input  logic [WORD_BITS-1:0] modulus,
	output logic                 done,
	output logic [WORD_BITS-1:0] product
);
	localparam int CW = $clog2(WORD_BITS);

	logic                 busy_q;
	logic                 done_q;
	logic [CW-1:0]        cnt_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] mcand_q;
	logic [WORD_BITS-1:0] mplier_q;
	logic [WORD_BITS-1:0] mod_q;

	logic [WORD_BITS+1:0] sum;
	logic [WORD_BITS+1:0] mod1;
	logic [WORD_BITS+1:0] mod2;
	logic [WORD_BITS+1:0] diff1;
	logic [WORD_BITS+1:0] diff2;
	logic [WORD_BITS-1:0] acc_next;

	// The running value stays below the modulus, so twice it plus the multiplicand
	// stays below three times the modulus and one subtraction of m or 2m reduces it.
	always_comb begin
		sum = {1'b0, acc_q, 1'b0}
			+ (mplier_q[WORD_BITS-1] ? {2'b00, mcand_q} : '0);
		mod1 = {2'b00, mod_q};
		mod2 = {1'b0, mod_q, 1'b0};
		diff1 = sum - mod1;
		diff2 = sum - mod2;
		if (sum >= mod2) begin
			acc_next = diff2[WORD_BITS-1:0];
		end else if (sum >= mod1) begin
			acc_next = diff1[WORD_BITS-1:0];
		end else begin
			acc_next = sum[WORD_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WORD_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			acc_q    <= '0;
			mcand_q  <= mcand;
			mplier_q <= mplier;
			mod_q    <= modulus;
		end else if (busy_q) begin
			acc_q    <= acc_next;
			mplier_q <= {mplier_q[WORD_BITS-2:0], 1'b0};
		end
	end

	assign done    = done_q;
	assign product = acc_q;
endmodule

FILE: sv/modular_exponentiation_top.sv
// Top level of the modular exponentiation block: sequencer, operand registers and output register.
// Computes base_value ** exponent mod modulus by right-to-left square-and-multiply. A transaction
// is accepted only while the block is idle; the output register then holds the result until it
// is taken, and the next operand transaction may be accepted meanwhile. Every modular product
// goes through one shared bit-serial multiplier; the first product reduces the base. An exponent
// of zero ends after that product, and a zero modulus skips the multiplier and flags an error.
// The modulus write channel is always ready.
module modular_exponentiation_top #(
	parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	mexp_cfg_if.sink cfg,
	mexp_in_if.sink operand,
	mexp_out_if.source result
);
	mexp_pkg::state_t  state_q;
	mexp_pkg::state_t  state_next;
	mexp_pkg::mm_cmd_t mm_cmd;

	logic [WORD_BITS-1:0] modulus_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] b_q;
	logic [WORD_BITS-1:0] e_q;
	logic                 err_q;
	logic                 out_valid_q;
	logic [WORD_BITS-1:0] out_result_q;
	logic                 out_error_q;

	logic                 accept;
	logic                 out_load;
	logic                 last_bit;
	logic                 mm_done;
	logic [WORD_BITS-1:0] mm_product;
	logic [WORD_BITS-1:0] mm_mcand;
	logic [WORD_BITS-1:0] mm_mplier;
	logic [WORD_BITS-1:0] b_cur;

	assign accept   = operand.valid && operand.ready;
	assign last_bit = (e_q[WORD_BITS-1:1] == '0);

	// A product that updates the base is passed straight on to the next product.
	assign b_cur = (mm_done && (state_q inside {mexp_pkg::ST_REDUCE, mexp_pkg::ST_SQUARE}))
		? mm_product : b_q;

	always_comb begin
		state_next = state_q;
		case (state_q)
			mexp_pkg::ST_IDLE: begin
				if (accept) begin
					state_next = (modulus_q == '0) ? mexp_pkg::ST_FINISH : mexp_pkg::ST_REDUCE;
				end
			end
			mexp_pkg::ST_REDUCE: begin
				if (mm_done) begin
					if (e_q == '0) begin
						state_next = mexp_pkg::ST_FINISH;
					end else if (e_q[0]) begin
						state_next = mexp_pkg::ST_MULACC;
					end else begin
						state_next = mexp_pkg::ST_SQUARE;
					end
				end
			end
			mexp_pkg::ST_MULACC: begin
				if (mm_done) begin
					state_next = last_bit ? mexp_pkg::ST_FINISH : mexp_pkg::ST_SQUARE;
				end
			end
			mexp_pkg::ST_SQUARE: begin
				if (mm_done) begin
					if (last_bit) begin
						state_next = mexp_pkg::ST_FINISH;
					end else if (e_q[1]) begin
						state_next = mexp_pkg::ST_MULACC;
					end else begin
						state_next = mexp_pkg::ST_SQUARE;
					end
				end
			end
			mexp_pkg::ST_FINISH: begin
				if (out_load) begin
					state_next = mexp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = mexp_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		operand.ready = 1'b0;
		out_load      = 1'b0;
		mm_cmd.start  = 1'b0;
		mm_cmd.sel    = mexp_pkg::OPS_REDUCE;
		case (state_q)
			mexp_pkg::ST_IDLE: begin
				operand.ready = 1'b1;
				mm_cmd.start  = operand.valid && (modulus_q != '0);
				mm_cmd.sel    = mexp_pkg::OPS_REDUCE;
			end
			mexp_pkg::ST_REDUCE: begin
				mm_cmd.start = mm_done && (e_q != '0);
				mm_cmd.sel   = e_q[0] ? mexp_pkg::OPS_MULACC : mexp_pkg::OPS_SQUARE;
			end
			mexp_pkg::ST_MULACC: begin
				mm_cmd.start = mm_done && !last_bit;
				mm_cmd.sel   = mexp_pkg::OPS_SQUARE;
			end
			mexp_pkg::ST_SQUARE: begin
				mm_cmd.start = mm_done && !last_bit;
				mm_cmd.sel   = e_q[1] ? mexp_pkg::OPS_MULACC : mexp_pkg::OPS_SQUARE;
			end
			mexp_pkg::ST_FINISH: begin
				out_load = !out_valid_q || result.ready;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_comb begin
		case (mm_cmd.sel)
			mexp_pkg::OPS_REDUCE: begin
				mm_mcand  = WORD_BITS'(1);
				mm_mplier = operand.base_value;
			end
			mexp_pkg::OPS_MULACC: begin
				mm_mcand  = acc_q;
				mm_mplier = b_cur;
			end
			mexp_pkg::OPS_SQUARE: begin
				mm_mcand  = b_cur;
				mm_mplier = b_cur;
			end
			default: begin
				mm_mcand  = b_cur;
				mm_mplier = b_cur;
			end
		endcase
	end

	mexp_mulmod #(
		.WORD_BITS(WORD_BITS)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_cmd.start),
		.mcand  (mm_mcand),
		.mplier (mm_mplier),
		.modulus(modulus_q),
		.done   (mm_done),
		.product(mm_product)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mexp_pkg::ST_IDLE;
			modulus_q   <= WORD_BITS'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cfg.valid && cfg.ready) begin
				modulus_q <= cfg.modulus;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			e_q   <= operand.exponent;
			err_q <= (modulus_q == '0);
			acc_q <= (modulus_q == '0) ? '0 : WORD_BITS'(1);
		end else if (mm_done) begin
			case (state_q)
				mexp_pkg::ST_REDUCE: begin
					b_q <= mm_product;
				end
				mexp_pkg::ST_MULACC: begin
					acc_q <= mm_product;
				end
				mexp_pkg::ST_SQUARE: begin
					b_q <= mm_product;
					e_q <= {1'b0, e_q[WORD_BITS-1:1]};
				end
				default: begin
					b_q <= b_q;
				end
			endcase
		end
		if (out_load) begin
			out_result_q <= acc_q;
			out_error_q  <= err_q;
		end
	end

	assign cfg.ready            = 1'b1;
	assign result.valid         = out_valid_q;
	assign result.power_result  = out_result_q;
	assign result.modulus_error = out_error_q;
endmodule

FILE: sv/mexp_checker.sv
// Port-level assertion checker for the modular exponentiation block, with its bind statement.
`include "modular_exponentiation_top_macros.svh"

module mexp_checker #(
	parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [WORD_BITS-1:0] cfg_modulus,
	input logic                 operand_valid,
	input logic                 operand_ready,
	input logic                 result_valid,
	input logic                 result_ready,
	input logic [WORD_BITS-1:0] result_power_result,
	input logic                 result_modulus_error
);
	logic [WORD_BITS-1:0] modulus_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_seen_q <= WORD_BITS'(1);
		end else if (cfg_valid && cfg_ready) begin
			modulus_seen_q <= cfg_modulus;
		end
	end

	`MEXP_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_power_result) && $stable(result_modulus_error), "Stalled result transaction changed")
	`MEXP_ASSERT_SAME(a_error_zero, result_valid && result_modulus_error, result_power_result == '0, "Modulus error with nonzero result")
	`MEXP_ASSERT_SAME(a_result_range, result_valid && !result_modulus_error, (result_power_result < modulus_seen_q) || (result_power_result == WORD_BITS'(1)), "Result not reduced by the modulus")
	`MEXP_ASSERT_NEXT(a_busy_after_accept, operand_valid && operand_ready, !operand_ready, "Operand accepted while a transaction is in progress")
endmodule

bind modular_exponentiation_top mexp_checker #(
	.WORD_BITS(WORD_BITS)
) u_mexp_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.cfg_valid           (cfg.valid),
	.cfg_ready           (cfg.ready),
	.cfg_modulus         (cfg.modulus),
	.operand_valid       (operand.valid),
	.operand_ready       (operand.ready),
	.result_valid        (result.valid),
	.result_ready        (result.ready),
	.result_power_result (result.power_result),
	.result_modulus_error(result.modulus_error)
);
